// ===== rtl/ser_pkg.sv =====
// shared types, character codes and the entity table of the entity rewriter
package ser_pkg;

    localparam int MAX_NAME_LEN_DEF = 7;
    localparam int WORD_MAX_LEN     = 7;
    localparam int KEY_MAX_LEN      = 4;
    localparam int ENTITY_COUNT     = 52;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;

    typedef enum logic [0:0] {
        SCAN_PLAIN = 1'b0,
        SCAN_NAME  = 1'b1
    } t_scan_mode;

    typedef struct packed {
        logic       is_match;
        logic [5:0] idx;
        logic       lead;
        logic       has_tail;
        logic [7:0] ch;
        logic       eot;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  klen;
        logic [31:0] key;
        logic [2:0]  wlen;
        logic [55:0] word;
    } t_entity;

    function automatic t_entity ent(input logic [2:0] klen, input logic [31:0] key,
                                    input logic [2:0] wlen, input logic [55:0] word);
        t_entity e;
        e.klen = klen;
        e.key  = key;
        e.wlen = wlen;
        e.word = word;
        return e;
    endfunction

    // keys and words are right justified, first character in the highest used byte
    function automatic t_entity ser_entity(input logic [5:0] idx);
        t_entity e;
        case (idx)
            6'd0:  e = ent(3'd3, "Agr",  3'd5, "Alpha");
            6'd1:  e = ent(3'd3, "Bgr",  3'd4, "Beta");
            6'd2:  e = ent(3'd3, "Dgr",  3'd5, "Delta");
            6'd3:  e = ent(3'd4, "EEgr", 3'd3, "Eta");
            6'd4:  e = ent(3'd3, "Egr",  3'd7, "Epsilon");
            6'd5:  e = ent(3'd3, "Ggr",  3'd5, "Gamma");
            6'd6:  e = ent(3'd3, "Igr",  3'd4, "Iota");
            6'd7:  e = ent(3'd4, "KHgr", 3'd3, "Chi");
            6'd8:  e = ent(3'd3, "Kgr",  3'd5, "Kappa");
            6'd9:  e = ent(3'd3, "Lgr",  3'd6, "Lambda");
            6'd10: e = ent(3'd3, "Mgr",  3'd2, "Mu");
            6'd11: e = ent(3'd3, "Ngr",  3'd2, "Nu");
            6'd12: e = ent(3'd4, "OHgr", 3'd5, "Omega");
            6'd13: e = ent(3'd3, "Ogr",  3'd7, "Omicron");
            6'd14: e = ent(3'd4, "PHgr", 3'd3, "Phi");
            6'd15: e = ent(3'd4, "PSgr", 3'd3, "Psi");
            6'd16: e = ent(3'd3, "Pgr",  3'd2, "Pi");
            6'd17: e = ent(3'd3, "Rgr",  3'd3, "Rho");
            6'd18: e = ent(3'd3, "Sgr",  3'd5, "Sigma");
            6'd19: e = ent(3'd4, "THgr", 3'd5, "Theta");
            6'd20: e = ent(3'd3, "Tgr",  3'd3, "Tau");
            6'd21: e = ent(3'd3, "Ugr",  3'd7, "Upsilon");
            6'd22: e = ent(3'd3, "Xgr",  3'd2, "Xi");
            6'd23: e = ent(3'd3, "Zgr",  3'd4, "Zeta");
            6'd24: e = ent(3'd3, "agr",  3'd5, "alpha");
            6'd25: e = ent(3'd3, "amp",  3'd1, "&");
            6'd26: e = ent(3'd3, "bgr",  3'd4, "beta");
            6'd27: e = ent(3'd3, "dgr",  3'd5, "delta");
            6'd28: e = ent(3'd4, "eegr", 3'd3, "eta");
            6'd29: e = ent(3'd3, "egr",  3'd7, "epsilon");
            6'd30: e = ent(3'd3, "ggr",  3'd5, "gamma");
            6'd31: e = ent(3'd2, "gt",   3'd1, ">");
            6'd32: e = ent(3'd3, "igr",  3'd4, "iota");
            6'd33: e = ent(3'd3, "kgr",  3'd5, "kappa");
            6'd34: e = ent(3'd4, "khgr", 3'd3, "chi");
            6'd35: e = ent(3'd3, "lgr",  3'd6, "lambda");
            6'd36: e = ent(3'd2, "lt",   3'd1, "<");
            6'd37: e = ent(3'd3, "mgr",  3'd2, "mu");
            6'd38: e = ent(3'd3, "ngr",  3'd2, "nu");
            6'd39: e = ent(3'd3, "ogr",  3'd7, "omicron");
            6'd40: e = ent(3'd4, "ohgr", 3'd5, "omega");
            6'd41: e = ent(3'd3, "pgr",  3'd2, "pi");
            6'd42: e = ent(3'd4, "phgr", 3'd3, "phi");
            6'd43: e = ent(3'd4, "psgr", 3'd3, "psi");
            6'd44: e = ent(3'd3, "rgr",  3'd3, "rho");
            6'd45: e = ent(3'd4, "sfgr", 3'd1, "s");
            6'd46: e = ent(3'd3, "sgr",  3'd5, "sigma");
            6'd47: e = ent(3'd3, "tgr",  3'd3, "tau");
            6'd48: e = ent(3'd4, "thgr", 3'd5, "theta");
            6'd49: e = ent(3'd3, "ugr",  3'd7, "upsilon");
            6'd50: e = ent(3'd3, "xgr",  3'd2, "xi");
            6'd51: e = ent(3'd3, "zgr",  3'd4, "zeta");
            default: e = ent(3'd0, 32'd0, 3'd0, 56'd0);
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/ser_front.sv =====
// front end: scans input beats, holds entity names, looks them up and queues emit commands
module ser_front #(
    parameter int MAX_NAME_LEN = ser_pkg::MAX_NAME_LEN_DEF,
    localparam int LW = $clog2(MAX_NAME_LEN + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [7:0]                  i_char,
    input  logic                        i_eot,
    output logic                        o_ready,
    input  logic                        i_q_ready,
    output logic                        o_push,
    output ser_pkg::t_cmd               o_cmd,
    output logic [MAX_NAME_LEN*8-1:0]   o_name,
    output logic [LW-1:0]               o_nlen
);

    ser_pkg::t_scan_mode r_mode, n_mode;
    logic [LW-1:0]       r_len, n_len;
    logic [7:0]          r_buf [MAX_NAME_LEN];

    logic                acc;
    logic                buf_we;
    logic                use_name;
    logic                hit;
    logic [5:0]          hit_idx;
    logic                same;
    ser_pkg::t_entity    lk_ent;

    assign o_ready = i_q_ready;
    assign acc     = i_valid && i_q_ready;

    // table lookup of the held name
    always_comb begin
        hit     = 1'b0;
        hit_idx = 6'd0;
        same    = 1'b0;
        lk_ent  = ser_pkg::ser_entity(6'd0);
        for (int r = 0; r < ser_pkg::ENTITY_COUNT; r++) begin
            lk_ent = ser_pkg::ser_entity(6'(r));
            same   = (r_len == LW'(lk_ent.klen));
            for (int j = 0; j < ser_pkg::KEY_MAX_LEN; j++) begin
                if (3'(j) < lk_ent.klen &&
                    r_buf[j] != 8'(lk_ent.key >> {lk_ent.klen - 3'(j) - 3'd1, 3'b000})) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                hit     = 1'b1;
                hit_idx = 6'(r);
            end
        end
    end

    always_comb begin
        n_mode          = r_mode;
        n_len           = r_len;
        buf_we          = 1'b0;
        use_name        = 1'b0;
        o_push          = 1'b0;
        o_cmd.is_match  = 1'b0;
        o_cmd.idx       = hit_idx;
        o_cmd.lead      = 1'b0;
        o_cmd.has_tail  = 1'b0;
        o_cmd.ch        = i_char;
        o_cmd.eot       = i_eot;
        unique case (r_mode)
            ser_pkg::SCAN_PLAIN: begin
                if (i_char == ser_pkg::CH_AMP) begin
                    n_mode     = ser_pkg::SCAN_NAME;
                    n_len      = '0;
                    o_push     = i_eot;
                    o_cmd.lead = 1'b1;
                end else begin
                    o_push         = 1'b1;
                    o_cmd.has_tail = 1'b1;
                end
            end
            ser_pkg::SCAN_NAME: begin
                if (i_char == ser_pkg::CH_SEMI) begin
                    o_push         = 1'b1;
                    o_cmd.is_match = hit;
                    o_cmd.lead     = !hit;
                    o_cmd.has_tail = !hit;
                    use_name       = !hit;
                    n_mode         = ser_pkg::SCAN_PLAIN;
                    n_len          = '0;
                end else if (i_char == ser_pkg::CH_AMP) begin
                    o_push         = 1'b1;
                    o_cmd.lead     = 1'b1;
                    o_cmd.has_tail = i_eot;
                    use_name       = 1'b1;
                    n_len          = '0;
                end else if (r_len < LW'(MAX_NAME_LEN)) begin
                    buf_we         = 1'b1;
                    n_len          = r_len + LW'(1);
                    o_push         = i_eot;
                    o_cmd.lead     = 1'b1;
                    o_cmd.has_tail = 1'b1;
                    use_name       = 1'b1;
                end else begin
                    o_push         = 1'b1;
                    o_cmd.lead     = 1'b1;
                    o_cmd.has_tail = 1'b1;
                    use_name       = 1'b1;
                    n_mode         = ser_pkg::SCAN_PLAIN;
                end
            end
            default: begin
                n_mode = ser_pkg::SCAN_PLAIN;
            end
        endcase
        if (i_eot) begin
            n_mode = ser_pkg::SCAN_PLAIN;
            n_len  = '0;
        end
        o_push = o_push && acc;
    end

    always_comb begin
        o_nlen = use_name ? r_len : '0;
        for (int i = 0; i < MAX_NAME_LEN; i++) begin
            o_name[i*8 +: 8] = r_buf[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ser_pkg::SCAN_PLAIN;
            r_len  <= '0;
        end else if (acc) begin
            r_mode <= n_mode;
            r_len  <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && buf_we) begin
            for (int i = 0; i < MAX_NAME_LEN; i++) begin
                if (LW'(i) == r_len) begin
                    r_buf[i] <= i_char;
                end
            end
        end
    end

endmodule

// ===== rtl/ser_queue.sv =====
// short command queue between the front end and the emit engine
module ser_queue #(
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_ready,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_pop
);

    localparam int QW = $clog2(ser_pkg::QUEUE_DEPTH);

    logic [DATA_W-1:0] r_slot [ser_pkg::QUEUE_DEPTH];
    logic [QW-1:0]     r_wr;
    logic [QW-1:0]     r_rd;
    logic [QW:0]       r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_cnt != (QW+1)'(ser_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (QW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (QW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/ser_back.sv =====
// emit engine: walks one queued command a byte per cycle into the output register while the output is not stalled
module ser_back #(
    parameter int MAX_NAME_LEN = ser_pkg::MAX_NAME_LEN_DEF,
    localparam int LW = $clog2(MAX_NAME_LEN + 1),
    localparam int CW = $clog2(MAX_NAME_LEN + ser_pkg::WORD_MAX_LEN + 3)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  ser_pkg::t_cmd               i_cmd,
    input  logic [MAX_NAME_LEN*8-1:0]   i_name,
    input  logic [LW-1:0]               i_nlen,
    output logic                        o_pop,
    output logic                        o_tvalid,
    input  logic                        i_tready,
    output logic [7:0]                  o_tdata,
    output logic                        o_tlast,
    output logic                        o_tuser
);

    logic [CW-1:0]    r_pos;
    logic             r_tvalid;
    logic [7:0]       r_tdata;
    logic             r_tlast;
    logic             r_tuser;

    ser_pkg::t_entity ent;
    logic [CW-1:0]    total;
    logic             last;
    logic             ld;
    logic [7:0]       n_char;
    logic [CW-1:0]    nk;
    logic [2:0]       w_k;
    logic [2:0]       w_rev;
    logic [7:0]       name_byte;

    assign ent = ser_pkg::ser_entity(i_cmd.idx);

    always_comb begin
        if (i_cmd.is_match) begin
            total = CW'(ent.wlen) + CW'(2);
        end else begin
            total = CW'(i_cmd.lead) + CW'(i_nlen) + CW'(i_cmd.has_tail);
        end
        last = (r_pos == total - CW'(1));
    end

    always_comb begin
        w_k       = 3'(r_pos - CW'(1));
        w_rev     = ent.wlen - 3'd1 - w_k;
        nk        = r_pos - CW'(i_cmd.lead);
        name_byte = i_name[7:0];
        for (int i = 0; i < MAX_NAME_LEN; i++) begin
            if (CW'(i) == nk) begin
                name_byte = i_name[i*8 +: 8];
            end
        end
        if (i_cmd.is_match) begin
            if (r_pos == '0) begin
                n_char = ser_pkg::CH_LT;
            end else if (r_pos == CW'(ent.wlen) + CW'(1)) begin
                n_char = ser_pkg::CH_GT;
            end else begin
                n_char = 8'(ent.word >> {w_rev, 3'b000});
            end
        end else if (i_cmd.lead && r_pos == '0) begin
            n_char = ser_pkg::CH_AMP;
        end else if (nk < CW'(i_nlen)) begin
            n_char = name_byte;
        end else begin
            n_char = i_cmd.ch;
        end
    end

    assign ld    = i_q_valid && (!r_tvalid || i_tready);
    assign o_pop = ld && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_tvalid <= 1'b0;
        end else if (ld) begin
            r_tvalid <= 1'b1;
            r_pos    <= last ? '0 : r_pos + CW'(1);
        end else if (i_tready) begin
            r_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_tdata <= n_char;
            r_tlast <= last;
            r_tuser <= last && i_cmd.eot;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;
    assign o_tuser  = r_tuser;

endmodule

// ===== rtl/sgml_entity_rewriter_core.sv =====
// top level of the entity rewriter: front end, command queue and emit engine
// accepts one input beat per cycle while the two-entry command queue has room
// an input beat that emits n bytes gives the emit engine n output beats, one per byte
// first output beat of an input passes the command queue and then the output register when the engine is free
// synchronous active-low reset clears scan mode, name length, queue and output valid
// the held name bytes are not reset
module sgml_entity_rewriter_core #(
    parameter int MAX_NAME_LEN = ser_pkg::MAX_NAME_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // char_in
    input  logic       i_s_axis_tlast,   // end_of_text
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // char_out
    output logic       o_m_axis_tlast,   // last_of_run
    output logic       o_m_axis_tuser    // text_done
);

    localparam int LW     = $clog2(MAX_NAME_LEN + 1);
    localparam int NW     = MAX_NAME_LEN * 8;
    localparam int CMD_W  = $bits(ser_pkg::t_cmd);
    localparam int DATA_W = NW + LW + CMD_W;

    logic              q_ready;
    logic              q_push;
    logic              q_valid;
    logic              q_pop;
    ser_pkg::t_cmd     f_cmd;
    logic [NW-1:0]     f_name;
    logic [LW-1:0]     f_nlen;
    logic [DATA_W-1:0] q_out;

    ser_front #(
        .MAX_NAME_LEN(MAX_NAME_LEN)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_char    (i_s_axis_tdata),
        .i_eot     (i_s_axis_tlast),
        .o_ready   (o_s_axis_tready),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_cmd     (f_cmd),
        .o_name    (f_name),
        .o_nlen    (f_nlen)
    );

    ser_queue #(
        .DATA_W(DATA_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_name, f_nlen, f_cmd}),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_out),
        .i_pop   (q_pop)
    );

    ser_back #(
        .MAX_NAME_LEN(MAX_NAME_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (ser_pkg::t_cmd'(q_out[CMD_W-1:0])),
        .i_name    (q_out[DATA_W-1 -: NW]),
        .i_nlen    (q_out[CMD_W +: LW]),
        .o_pop     (q_pop),
        .o_tvalid  (o_m_axis_tvalid),
        .i_tready  (i_m_axis_tready),
        .o_tdata   (o_m_axis_tdata),
        .o_tlast   (o_m_axis_tlast),
        .o_tuser   (o_m_axis_tuser)
    );

endmodule

// ===== rtl/ser_checker.sv =====
// port-level checks for the entity rewriter and their binding to the top level
module ser_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast,
    input logic       o_m_axis_tuser
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) &&
            $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser))
        else $error("output beat changed while stalled");

    // end of text only on the last beat of a run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("text done without end of run");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready right after reset");

    // nothing pending means no output can appear without a prior input beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) && !(i_s_axis_tvalid && o_s_axis_tready) |=> !o_m_axis_tvalid)
        else $error("output beat with nothing accepted");

endmodule

bind sgml_entity_rewriter_core ser_checker u_ser_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
